### design/evb_pkg.sv
// package with payload types and constants of the edge vignette blend unit
package evb_pkg;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int ALPHA_W = 8;
    localparam int THK_W   = 10;
    localparam int POS_W   = 13;
    localparam int NUM_W   = ALPHA_W + THK_W;
    localparam int PROD_W  = 2 * CH_W;
    localparam int NUM_CH  = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_COLOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALPHA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THICKNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_START     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_END       = 3'd4;

    localparam logic [COL_W-1:0] SPAN_END_RESET = 10'd640;
    localparam logic [CH_W-1:0]  ALPHA_FULL     = 8'd255;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             was_blended;
    } out_item_t;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] pix;
    } carry_t;

endpackage

### design/edge_vignette_blend_unit.sv
// edge vignette blend unit: pipelined per-pixel edge alpha blend
// The unit takes one pixel per clock unless stalled. Two stages find the larger of
// the column distance to the nearest span edge and the row distance to the nearest
// screen edge, one multiplies by max_alpha, eight stages of a restoring divider
// (one quotient bit each) form the alpha, and three stages blend the three channels
// and scale by 1/255. The whole pipeline holds while a finished result is not taken,
// so s_ready follows m_ready whenever the output register is full. Configuration
// writes are taken every cycle and must only be issued while no pixel is in flight.
module edge_vignette_blend_unit #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  evb_pkg::in_item_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output evb_pkg::out_item_t                     m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [evb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [evb_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int DIV_N = evb_pkg::ALPHA_W;
    localparam logic [evb_pkg::POS_W-1:0] SW = evb_pkg::POS_W'(SCREEN_WIDTH);
    localparam logic [evb_pkg::POS_W-1:0] SH = evb_pkg::POS_W'(SCREEN_HEIGHT);

    // configuration registers
    logic [evb_pkg::PIX_W-1:0]   blend_color_reg;
    logic [evb_pkg::ALPHA_W-1:0] max_alpha_reg;
    logic [evb_pkg::THK_W-1:0]   edge_thickness_reg;
    logic [evb_pkg::COL_W-1:0]   span_start_reg;
    logic [evb_pkg::COL_W-1:0]   span_end_reg;

    logic advance;

    // stage 1
    logic                         p1_v_reg, p1_v_next;
    evb_pkg::carry_t              p1_c_reg, p1_c_next;
    logic [evb_pkg::COL_W-1:0]    p1_i_reg, p1_i_next;
    logic [evb_pkg::COL_W-1:0]    p1_wm1_reg, p1_wm1_next;
    logic [evb_pkg::ROW_W-1:0]    p1_dy_reg, p1_dy_next;

    // stage 2
    logic                         p2_v_reg;
    evb_pkg::carry_t              p2_c_reg, p2_c_next;
    logic [evb_pkg::THK_W-1:0]    p2_diff_reg, p2_diff_next;

    // divider stages, index 0 holds the product
    logic                         dv_v_reg   [DIV_N+1];
    evb_pkg::carry_t              dv_c_reg   [DIV_N+1];
    logic [evb_pkg::NUM_W-1:0]    dv_rem_reg [DIV_N+1];
    logic [evb_pkg::ALPHA_W-1:0]  dv_q_reg   [DIV_N+1];
    logic [evb_pkg::NUM_W-1:0]    dv_rem_next [DIV_N+1];
    logic [evb_pkg::ALPHA_W-1:0]  dv_q_next   [DIV_N+1];

    // blend stages
    logic                         p4_v_reg, p5_v_reg;
    logic                         p4_blend_reg, p4_blend_next, p5_blend_reg;
    logic [evb_pkg::PIX_W-1:0]    p4_pix_reg, p5_pix_reg;
    logic [evb_pkg::PROD_W-1:0]   p4_ps_reg [evb_pkg::NUM_CH];
    logic [evb_pkg::PROD_W-1:0]   p4_pd_reg [evb_pkg::NUM_CH];
    logic [evb_pkg::PROD_W-1:0]   p4_ps_next [evb_pkg::NUM_CH];
    logic [evb_pkg::PROD_W-1:0]   p4_pd_next [evb_pkg::NUM_CH];
    logic [evb_pkg::PROD_W-1:0]   p5_sum_reg [evb_pkg::NUM_CH];

    // output register
    logic                         m_valid_reg;
    evb_pkg::out_item_t           m_data_reg, m_data_next;

    assign advance   = m_ready || !m_valid_reg;
    assign s_ready   = advance;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_color_reg    <= '0;
            max_alpha_reg      <= '0;
            edge_thickness_reg <= '0;
            span_start_reg     <= '0;
            span_end_reg       <= evb_pkg::SPAN_END_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                evb_pkg::CFG_BLEND_COLOR:    blend_color_reg    <= cfg_data;
                evb_pkg::CFG_MAX_ALPHA:      max_alpha_reg      <= cfg_data[evb_pkg::ALPHA_W-1:0];
                evb_pkg::CFG_EDGE_THICKNESS: edge_thickness_reg <= cfg_data[evb_pkg::THK_W-1:0];
                evb_pkg::CFG_SPAN_START:     span_start_reg     <= cfg_data[evb_pkg::COL_W-1:0];
                evb_pkg::CFG_SPAN_END:       span_end_reg       <= cfg_data[evb_pkg::COL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage 1: span clamp, span and row checks, offsets
    always_comb begin
        logic                      enabled;
        logic [evb_pkg::COL_W-1:0] hi;
        logic [evb_pkg::POS_W-1:0] row_w;
        logic [evb_pkg::POS_W-1:0] dyr;
        logic                      in_col;
        logic                      in_row;
        enabled = (span_end_reg > span_start_reg) && (edge_thickness_reg != '0)
                  && (max_alpha_reg != '0);
        hi = ({3'b0, span_end_reg} > SW) ? SW[evb_pkg::COL_W-1:0] : span_end_reg;
        in_col = (s_data.column >= span_start_reg) && (s_data.column < hi);
        row_w = {4'b0, s_data.row};
        in_row = row_w < SH;
        dyr = SH - 13'd1 - row_w;
        p1_v_next = s_valid;
        p1_c_next.ok = enabled && in_col && in_row;
        p1_c_next.pix = s_data.pixel_in;
        p1_i_next = s_data.column - span_start_reg;
        p1_wm1_next = hi - span_start_reg - 10'd1;
        p1_dy_next = (row_w < dyr) ? s_data.row : dyr[evb_pkg::ROW_W-1:0];
    end

    // stage 2: larger of the column and row edge distances, alpha numerator term
    always_comb begin
        logic [evb_pkg::COL_W-1:0] dxr;
        logic [evb_pkg::COL_W-1:0] dx;
        logic [evb_pkg::COL_W-1:0] d;
        dxr = p1_wm1_reg - p1_i_reg;
        dx = (p1_i_reg < dxr) ? p1_i_reg : dxr;
        d = (dx > {1'b0, p1_dy_reg}) ? dx : {1'b0, p1_dy_reg};
        p2_c_next.ok = p1_c_reg.ok && (d < edge_thickness_reg);
        p2_c_next.pix = p1_c_reg.pix;
        p2_diff_next = edge_thickness_reg - d;
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        logic [evb_pkg::NUM_W:0] trial;
        dv_rem_next[0] = evb_pkg::NUM_W'(max_alpha_reg) * evb_pkg::NUM_W'(p2_diff_reg);
        dv_q_next[0]   = '0;
        for (int j = 0; j < DIV_N; j++) begin
            trial = {1'b0, dv_rem_reg[j]}
                    - (({9'b0, edge_thickness_reg}) << (DIV_N - 1 - j));
            dv_rem_next[j+1] = trial[evb_pkg::NUM_W] ? dv_rem_reg[j]
                                                       : trial[evb_pkg::NUM_W-1:0];
            dv_q_next[j+1] = {dv_q_reg[j][evb_pkg::ALPHA_W-2:0], ~trial[evb_pkg::NUM_W]};
        end
    end

    // channel products
    always_comb begin
        logic [evb_pkg::ALPHA_W-1:0] a;
        logic [evb_pkg::ALPHA_W-1:0] ia;
        logic [evb_pkg::PIX_W-1:0]   src;
        a  = dv_q_reg[DIV_N];
        ia = evb_pkg::ALPHA_FULL - a;
        // color register is bbggrr
        src = {blend_color_reg[7:0], blend_color_reg[15:8], blend_color_reg[23:16]};
        p4_blend_next = dv_c_reg[DIV_N].ok && (a != '0);
        for (int c = 0; c < evb_pkg::NUM_CH; c++) begin
            p4_ps_next[c] = evb_pkg::PROD_W'(src[c*evb_pkg::CH_W +: evb_pkg::CH_W])
                            * evb_pkg::PROD_W'(a);
            p4_pd_next[c] = evb_pkg::PROD_W'(dv_c_reg[DIV_N].pix[c*evb_pkg::CH_W +: evb_pkg::CH_W])
                            * evb_pkg::PROD_W'(ia);
        end
    end

    // divide by 255 and select
    always_comb begin
        logic [evb_pkg::PROD_W:0]  x;
        logic [evb_pkg::PIX_W-1:0] mixed;
        mixed = '0;
        for (int c = 0; c < evb_pkg::NUM_CH; c++) begin
            x = {1'b0, p5_sum_reg[c]} + {9'b0, p5_sum_reg[c][15:8]} + 17'd1;
            mixed[c*evb_pkg::CH_W +: evb_pkg::CH_W] = x[15:8];
        end
        m_data_next.pixel_out   = p5_blend_reg ? mixed : p5_pix_reg;
        m_data_next.was_blended = p5_blend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            p4_v_reg    <= 1'b0;
            p5_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int j = 0; j <= DIV_N; j++) begin
                dv_v_reg[j] <= 1'b0;
            end
        end else if (advance) begin
            p1_v_reg    <= p1_v_next;
            p2_v_reg    <= p1_v_reg;
            dv_v_reg[0] <= p2_v_reg;
            for (int j = 0; j < DIV_N; j++) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
            p4_v_reg    <= dv_v_reg[DIV_N];
            p5_v_reg    <= p4_v_reg;
            m_valid_reg <= p5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_c_reg    <= p1_c_next;
            p1_i_reg    <= p1_i_next;
            p1_wm1_reg  <= p1_wm1_next;
            p1_dy_reg   <= p1_dy_next;
            p2_c_reg    <= p2_c_next;
            p2_diff_reg <= p2_diff_next;
            dv_c_reg[0]   <= p2_c_reg;
            dv_rem_reg[0] <= dv_rem_next[0];
            dv_q_reg[0]   <= dv_q_next[0];
            for (int j = 0; j < DIV_N; j++) begin
                dv_c_reg[j+1]   <= dv_c_reg[j];
                dv_rem_reg[j+1] <= dv_rem_next[j+1];
                dv_q_reg[j+1]   <= dv_q_next[j+1];
            end
            p4_blend_reg <= p4_blend_next;
            p4_pix_reg   <= dv_c_reg[DIV_N].pix;
            p5_blend_reg <= p4_blend_reg;
            p5_pix_reg   <= p4_pix_reg;
            for (int c = 0; c < evb_pkg::NUM_CH; c++) begin
                p4_ps_reg[c]  <= p4_ps_next[c];
                p4_pd_reg[c]  <= p4_pd_next[c];
                p5_sum_reg[c] <= p4_ps_reg[c] + p4_pd_reg[c];
            end
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // a transfer always lands in the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> p1_v_reg)
        else $error("accepted pixel missing from first stage");

    // alpha never exceeds max_alpha
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v_reg[DIV_N] && dv_c_reg[DIV_N].ok) |-> (dv_q_reg[DIV_N] <= max_alpha_reg))
        else $error("alpha above max_alpha");

    // divider remainder ends below the thickness
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_v_reg[DIV_N] && dv_c_reg[DIV_N].ok)
        |-> (dv_rem_reg[DIV_N] < {8'b0, edge_thickness_reg}))
        else $error("divider remainder out of range");

    // zero max_alpha never blends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (max_alpha_reg == '0)) |-> !m_data_reg.was_blended)
        else $error("blend with zero max_alpha");
`endif

endmodule
